// File: sv/tes_pkg.sv
// Package: shared constants, types and field widths of the timer event scheduler.
package tes_pkg;

  localparam int NumSlotsDefault = 16;
  localparam int TimeW = 32;
  localparam int TolW = 16;
  localparam int CondW = 16;
  localparam int SlotW = 4;
  localparam logic [TolW-1:0] TolReset = 16'd5;

  typedef enum logic [1:0] {
    KIND_ONESHOT  = 2'd0,
    KIND_PERIODIC = 2'd1,
    KIND_COND     = 2'd2,
    KIND_COND_ALT = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_TICK     = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_APPLY = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

  // One slot record as it moves along the ring of cells.
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [TimeW-1:0]  due;
    logic [TimeW-1:0]  period;
  } slot_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic shift;     // rotate ring by one
    logic write;     // overwrite head cell with wr_slot
  } cell_ctrl_t;

endpackage

// File: sv/tes_cell.sv
// One slot cell of the rotating timer ring.
module tes_cell
  import tes_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       head_i,
  input  slot_t      wr_slot_i,
  input  slot_t      prev_i,
  output slot_t      slot_o
);

  slot_t            slot_d;
  logic             valid_q;
  logic [1:0]       kind_q;
  logic [TimeW-1:0] due_q, period_q;

  assign slot_o = {valid_q, kind_q, due_q, period_q};

  always_comb begin
    slot_d = slot_o;
    if (ctrl_i.write && head_i) begin
      slot_d = wr_slot_i;
    end else if (ctrl_i.shift) begin
      slot_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= slot_d.kind;
    due_q    <= slot_d.due;
    period_q <= slot_d.period;
  end

endmodule

// File: sv/timer_event_scheduler_top.sv
// Top level: timer slot ring, scan sequencer and stream ports.
// Timer slots sit in a ring of NUM_SLOTS cells that rotates by one position per
// clock while an item is scanned or its slot is sought; the head cell is examined
// as it passes. Every item (register or tick) is accepted while idle, then takes
// one full rotation to find the lowest free slot or the earliest due slot, further
// shifts to bring the chosen slot back to the head, and a final step to update it
// and post the result, which waits while the output register is still full.
// One item is in work at a time; a result waits in the output register until
// taken, and the next result is held back until then.
module timer_event_scheduler_top
  import tes_pkg::*;
#(
  parameter int NUM_SLOTS = NumSlotsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,       // late_tolerance
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tuser,      // [0] cmd, [2:1] timer_kind, zero fill
  input  logic [111:0] s_axis_tdata,      // start_time, period, now_time, cond_mask
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata       // fired, fired_slot[4], late, dropped, table_full
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);

  state_e state_q, state_d;
  logic [TolW-1:0] tol_q;

  // captured item
  logic             cmd_q;
  logic [1:0]       kind_q;
  logic [TimeW-1:0] start_q, per_q, now_q;
  logic [CondW-1:0] cond_q;

  // scan bookkeeping: pos_q is the slot number at the head
  logic [IdxW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [TimeW-1:0] bdue_q, bdue_d;
  logic [1:0]      bkind_q, bkind_d;

  logic [7:0] res_q, res_d;
  logic       ovalid_q, ovalid_d;

  slot_t      ring [NUM_SLOTS];
  slot_t      wr_slot;
  cell_ctrl_t ctrl;
  slot_t      head;

  assign head = ring[0];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    tes_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i   (ctrl),
      .head_i   (g == 0),
      .wr_slot_i(wr_slot),
      .prev_i   (ring[(g + 1) % NUM_SLOTS]),
      .slot_o   (ring[g])
    );
  end

  logic better;
  logic due_ok, cond_ok, late;
  logic [TimeW-1:0] lag;
  logic [SlotW-1:0] slot4;

  always_comb begin
    better = 1'b0;
    // scan starts anywhere; equal due: non-one-shot first, then lower slot number
    if (head.valid) begin
      better = !found_q || (head.due < bdue_q) ||
               ((head.due == bdue_q) &&
                (((bkind_q == KIND_ONESHOT) && (head.kind != KIND_ONESHOT)) ||
                 (((bkind_q == KIND_ONESHOT) == (head.kind == KIND_ONESHOT)) &&
                  (pos_q < best_q))));
    end
    due_ok  = found_q && (bdue_q <= now_q);
    cond_ok = 1'b1;
    if (bkind_q == KIND_COND) begin
      cond_ok = (32'(best_q) < CondW) && cond_q[SlotW'(best_q)];
    end
    lag   = now_q - bdue_q;
    late  = lag > TimeW'(tol_q);
    slot4 = SlotW'(32'(best_q) & 32'hF);
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    best_d   = best_q;
    bdue_d   = bdue_q;
    bkind_d  = bkind_q;
    res_d    = res_q;
    ovalid_d = ovalid_q;
    ctrl     = '0;
    wr_slot  = head;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // one head cell per cycle, then rotate
        if (cmd_q == CMD_REGISTER) begin
          if (!head.valid && (!found_q || (pos_q < best_q))) begin
            found_d = 1'b1;
            best_d  = pos_q;
          end
        end else if (better) begin
          found_d = 1'b1;
          best_d  = pos_q;
          bdue_d  = head.due;
          bkind_d = head.kind;
        end
        ctrl.shift = 1'b1;
        pos_d = (32'(pos_q) == NUM_SLOTS - 1) ? '0 : pos_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == NUM_SLOTS - 1) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (pos_q != best_q && found_q) begin
          ctrl.shift = 1'b1;
          pos_d = (32'(pos_q) == NUM_SLOTS - 1) ? '0 : pos_q + 1'b1;
        end else if (!ovalid_q || m_axis_tready) begin
          state_d  = ST_IDLE;
          ovalid_d = 1'b1;
          res_d    = '0;
          if (cmd_q == CMD_REGISTER) begin
            if (found_q) begin
              ctrl.write     = 1'b1;
              wr_slot.valid  = 1'b1;
              wr_slot.kind   = (kind_q == KIND_COND_ALT) ? KIND_COND : kind_q;
              wr_slot.due    = start_q;
              wr_slot.period = per_q;
              res_d[4:1]     = slot4;
            end else begin
              res_d[7] = 1'b1;
            end
          end else if (due_ok) begin
            ctrl.write = 1'b1;
            res_d[4:1] = slot4;
            if (!cond_ok) begin
              wr_slot.valid = 1'b0;
              res_d[6] = 1'b1;
            end else begin
              res_d[0] = 1'b1;
              res_d[5] = late;
              if (bkind_q == KIND_ONESHOT) wr_slot.valid = 1'b0;
              else wr_slot.due = head.due + head.period;
            end
          end
        end
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tol_q    <= TolReset;
      pos_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    bdue_q  <= bdue_d;
    bkind_q <= bkind_d;
    res_q   <= res_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q   <= s_axis_tuser[0];
      kind_q  <= s_axis_tuser[2:1];
      start_q <= s_axis_tdata[31:0];
      per_q   <= s_axis_tdata[63:32];
      now_q   <= s_axis_tdata[95:64];
      cond_q  <= s_axis_tdata[111:96];
    end
  end

endmodule

// File: verif/tes_checker.sv
// Checker: predicts timer scheduler results from observed transfers and compares them.
`timescale 1ns / 100ps
module tes_checker
  import tes_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tuser,
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  output int           fail_cnt_o,
  output int           pending_o
);

  logic             tmr_valid [NumSlotsDefault];
  kind_e            tmr_kind [NumSlotsDefault];
  logic [TimeW-1:0] tmr_due [NumSlotsDefault];
  logic [TimeW-1:0] tmr_period [NumSlotsDefault];
  logic [TolW-1:0]  tolerance;
  // small ring of predicted results; at most two are ever outstanding
  logic [7:0]       outcome_mem [8];
  logic [2:0]       wr_ptr, rd_ptr;
  int               fill;

  // Packed result: fired, slot, late, dropped, full from bit 0 up.
  function automatic logic [7:0] pack_outcome(logic f, logic [3:0] s, logic l, logic d,
                                              logic full);
    return {full, d, l, s, f};
  endfunction

  task automatic queue_outcome(input logic [7:0] v);
    outcome_mem[wr_ptr] = v;
    wr_ptr = wr_ptr + 3'd1;
    fill   = fill + 1;
  endtask

  task automatic schedule_item(input logic [7:0] user, input logic [111:0] data);
    cmd_e             cmd;
    logic [1:0]       kind;
    logic [TimeW-1:0] start, per, now;
    logic [CondW-1:0] cond;
    int               best;
    logic             done;
    cmd   = cmd_e'(user[0]);
    kind  = user[2:1];
    start = data[31:0];
    per   = data[63:32];
    now   = data[95:64];
    cond  = data[111:96];
    best  = -1;
    done  = 1'b0;
    if (cmd == CMD_REGISTER) begin
      for (int s = 0; s < NumSlotsDefault; s++) begin
        if (!done && !tmr_valid[s]) begin
          tmr_valid[s]  = 1'b1;
          tmr_kind[s]   = (kind == KIND_COND_ALT) ? KIND_COND : kind_e'(kind);
          tmr_due[s]    = start;
          tmr_period[s] = per;
          queue_outcome(pack_outcome(1'b0, s[3:0], 1'b0, 1'b0, 1'b0));
          done = 1'b1;
        end
      end
      if (!done) queue_outcome(pack_outcome(1'b0, 4'd0, 1'b0, 1'b0, 1'b1));
      return;
    end
    for (int s = 0; s < NumSlotsDefault; s++) begin
      if (tmr_valid[s]) begin
        if (best < 0 || tmr_due[s] < tmr_due[best] ||
            (tmr_due[s] == tmr_due[best] && tmr_kind[best] == KIND_ONESHOT &&
             tmr_kind[s] != KIND_ONESHOT))
          best = s;
      end
    end
    if (best < 0 || tmr_due[best] > now) begin
      queue_outcome(pack_outcome(1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
    end else if (tmr_kind[best] == KIND_COND && !cond[best]) begin
      tmr_valid[best] = 1'b0;
      queue_outcome(pack_outcome(1'b0, best[3:0], 1'b0, 1'b1, 1'b0));
    end else begin
      queue_outcome(pack_outcome(1'b1, best[3:0],
                                 (now - tmr_due[best]) > {16'd0, tolerance},
                                 1'b0, 1'b0));
      if (tmr_kind[best] == KIND_ONESHOT) tmr_valid[best] = 1'b0;
      else tmr_due[best] = tmr_due[best] + tmr_period[best];
    end
  endtask

  assign pending_o = fill;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_cnt_o <= 0;
      tolerance = TolReset;
      for (int s = 0; s < NumSlotsDefault; s++) tmr_valid[s] = 1'b0;
      wr_ptr = 3'd0;
      rd_ptr = 3'd0;
      fill   = 0;
    end else begin
      if (cfg_we_i) tolerance = cfg_wdata_i;
      // outputs first: a result cannot belong to the item taken in this same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (fill == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          logic [7:0] want;
          want   = outcome_mem[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          fill   = fill - 1;
          if (want !== m_axis_tdata) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, want,
                     m_axis_tdata);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) schedule_item(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top: clock, reset, stimulus for the timer scheduler and the verdict.
`timescale 1ns / 100ps
module tb_top;
  import tes_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tuser = '0;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  int           fail_cnt, pending;
  int           send_idle = 0, recv_stall = 0;
  int           quiet_cycles = 0;
  logic [31:0]  clock_now = 32'd0;

  localparam int QuietLimit = 20000;

  always #4 clk_i = ~clk_i;

  timer_event_scheduler_top dut (.*);

  tes_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tuser, .s_axis_tdata, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // the block is busy scanning after a transfer, so the gap that send leaves
  // between items costs nothing
  task automatic send(input cmd_e cmd, input logic [1:0] kind, input logic [31:0] start,
                      input logic [31:0] per, input logic [31:0] now,
                      input logic [15:0] cond);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {5'd0, kind, cmd};
    s_axis_tdata  <= {cond, now, per, start};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic set_tolerance(input logic [15:0] tol);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= tol;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [31:0] due;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 40) begin
        due = clock_now + $urandom_range(40);
        if ($urandom_range(9) == 0) due = $urandom;
        send(CMD_REGISTER, 2'($urandom_range(3)), due,
             ($urandom_range(7) == 0) ? $urandom : $urandom_range(30), $urandom,
             16'($urandom));
      end else begin
        clock_now = clock_now + $urandom_range(12);
        if ($urandom_range(30) == 0) clock_now = $urandom;
        send(CMD_TICK, 2'($urandom_range(3)), $urandom, $urandom, clock_now,
             16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: empty tick, fill table, full, ties, late, drop, extremes
    send(CMD_TICK, 2'd0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF);
    send(CMD_REGISTER, KIND_ONESHOT, 32'd100, 32'd0, '0, '0);
    send(CMD_REGISTER, KIND_PERIODIC, 32'd100, 32'd0, '1, '1);
    send(CMD_REGISTER, KIND_COND, 32'd50, 32'hFFFF_FFFF, '0, '0);
    send(CMD_REGISTER, KIND_COND_ALT, 32'd60, 32'd10, '0, '0);
    send(CMD_TICK, 2'd0, '0, '0, 32'd49, 16'h0000);
    send(CMD_TICK, 2'd0, '0, '0, 32'd50, 16'h0000);
    send(CMD_TICK, 2'd0, '0, '0, 32'd70, 16'hFFFF);
    send(CMD_TICK, 2'd0, '0, '0, 32'd100, 16'hFFFF);
    send(CMD_TICK, 2'd0, '0, '0, 32'd105, 16'hFFFF);
    send(CMD_TICK, 2'd0, '0, '0, 32'd200, 16'hFFFF);
    for (int s = 0; s < 17; s++)
      send(CMD_REGISTER, KIND_PERIODIC, 32'hFFFF_FFF0, 32'h20, '0, '0);
    send(CMD_TICK, 2'd0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF);
    random_phase(40);
    set_tolerance(16'd0);
    random_phase(280);
    send_idle = 70;
    set_tolerance(16'hFFFF);
    random_phase(280);
    send_idle = 0;
    recv_stall = 70;
    set_tolerance(16'd3);
    random_phase(280);
    send_idle = 7;
    recv_stall = 7;
    set_tolerance(16'd5);
    random_phase(250);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
